@@ rtl/cpg_pkg.sv @@
`timescale 1ns / 1ps
package cpg_pkg;

  typedef enum logic {
    KIND_START   = 1'b0,
    KIND_ADVANCE = 1'b1
  } kind_t;

  localparam int PointsPerItem = 16;

  typedef logic [$clog2(PointsPerItem)-1:0] pt_idx_t;

  localparam pt_idx_t LAST_POINT = pt_idx_t'(PointsPerItem - 1);

  // decision variable terms
  localparam int D_INIT    = 3;
  localparam int D_STEP_X  = 6;
  localparam int D_STEP_XY = 10;

endpackage

@@ rtl/circle_point_generator.sv @@
`timescale 1ns / 1ps
// midpoint circle rasterizer, eight-way symmetric
// input channel (in_valid/in_ready): kind 0 starts a circle from center_x,
//   center_y and radius and gives no output; kind 1 advances one step
// output channel (out_valid/out_ready): one point per word, sixteen words
//   per productive advance, last on the sixteenth, finished on every word
//   of the step that completes the circle
// an advance with no circle in progress, or after completion, gives nothing
// first point: the advance word loads the emitter job, then the output register
// throughput: one output word per cycle while the receiver is ready, so an
//   advance holds the single output port for its sixteen words; the next word
//   is taken at the edge that moves the sixteenth point into the output register
// a stalled receiver holds the output register and the burst in place;
//   input is taken again once the burst drains
// reset clears the circle state and drops any burst in flight
module circle_point_generator import cpg_pkg::*; #(
  parameter int COORD_BITS = 10
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         kind,
  input  logic signed [COORD_BITS-1:0] center_x,
  input  logic signed [COORD_BITS-1:0] center_y,
  input  logic [COORD_BITS-2:0]        radius,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [COORD_BITS:0]   point_x,
  output logic signed [COORD_BITS:0]   point_y,
  output logic                         last,
  output logic                         finished
);

  localparam int SW = COORD_BITS + 1;
  localparam int DW = COORD_BITS + 4;

  logic signed [SW-1:0]         step_x;
  logic signed [SW-1:0]         step_y;
  logic signed [DW-1:0]         decision;
  logic signed [COORD_BITS-1:0] centre_x_held;
  logic signed [COORD_BITS-1:0] centre_y_held;
  logic                         active;

  logic                         accept;
  logic                         can_load;
  logic                         can_run;
  logic                         load;
  logic                         d_neg;
  logic signed [SW-1:0]         x_next;
  logic signed [SW-1:0]         y_next;
  logic signed [SW-1:0]         diff;
  logic signed [DW-1:0]         dx;
  logic signed [DW-1:0]         decision_next;
  logic                         done_after;

  assign in_ready = can_load;
  assign accept   = in_valid && in_ready;

  always_comb begin
    d_neg         = decision[DW-1];
    x_next        = step_x + SW'(1);
    y_next        = d_neg ? step_y : (step_y - SW'(1));
    diff          = x_next - y_next;
    dx            = d_neg ? DW'(x_next) : DW'(diff);
    decision_next = decision + (dx <<< 2)
                  + (d_neg ? DW'(D_STEP_X) : DW'(D_STEP_XY));
    done_after    = x_next > y_next;
    can_run       = active && (step_x <= step_y);
    load          = accept && (kind_t'(kind) == KIND_ADVANCE) && can_run;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_x        <= '0;
      step_y        <= '0;
      decision      <= '0;
      centre_x_held <= '0;
      centre_y_held <= '0;
      active        <= 1'b0;
    end else if (accept) begin
      if (kind_t'(kind) == KIND_START) begin
        centre_x_held <= center_x;
        centre_y_held <= center_y;
        step_x        <= '0;
        step_y        <= SW'(radius);
        decision      <= DW'(D_INIT) - (DW'(radius) <<< 1);
        active        <= 1'b1;
      end else if (can_run) begin
        step_x   <= x_next;
        step_y   <= y_next;
        decision <= decision_next;
        active   <= !done_after;
      end else begin
        active <= 1'b0;
      end
    end
  end

  cpg_octant_emit #(
    .COORD_BITS(COORD_BITS)
  ) u_emit (
    .clk      (clk),
    .rst      (rst),
    .load     (load),
    .cx       (centre_x_held),
    .cy       (centre_y_held),
    .x0       (step_x),
    .y0       (step_y),
    .x1       (x_next),
    .y1       (y_next),
    .done     (done_after),
    .can_load (can_load),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .point_x  (point_x),
    .point_y  (point_y),
    .last     (last),
    .finished (finished)
  );

endmodule

@@ rtl/cpg_octant_emit.sv @@
`timescale 1ns / 1ps
module cpg_octant_emit import cpg_pkg::*; #(
  parameter int COORD_BITS = 10
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         load,
  input  logic signed [COORD_BITS-1:0] cx,
  input  logic signed [COORD_BITS-1:0] cy,
  input  logic signed [COORD_BITS:0]   x0,
  input  logic signed [COORD_BITS:0]   y0,
  input  logic signed [COORD_BITS:0]   x1,
  input  logic signed [COORD_BITS:0]   y1,
  input  logic                         done,
  output logic                         can_load,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [COORD_BITS:0]   point_x,
  output logic signed [COORD_BITS:0]   point_y,
  output logic                         last,
  output logic                         finished
);

  localparam int PW = COORD_BITS + 2;

  logic                         busy;
  pt_idx_t                      idx;
  logic signed [COORD_BITS-1:0] job_cx;
  logic signed [COORD_BITS-1:0] job_cy;
  logic signed [COORD_BITS:0]   job_x0;
  logic signed [COORD_BITS:0]   job_y0;
  logic signed [COORD_BITS:0]   job_x1;
  logic signed [COORD_BITS:0]   job_y1;
  logic                         job_done;

  logic                         out_free;
  logic                         move;
  logic signed [COORD_BITS:0]   cur_x;
  logic signed [COORD_BITS:0]   cur_y;
  logic signed [COORD_BITS:0]   a;
  logic signed [COORD_BITS:0]   b;
  logic signed [PW-1:0]         px;
  logic signed [PW-1:0]         py;

  assign out_free = !out_valid || out_ready;
  assign move     = busy && out_free;
  assign can_load = !busy || (move && idx == LAST_POINT);

  // upper half of the burst uses the stepped position
  always_comb begin
    cur_x = idx[3] ? job_x1 : job_x0;
    cur_y = idx[3] ? job_y1 : job_y0;
    a     = idx[2] ? cur_y : cur_x;
    b     = idx[2] ? cur_x : cur_y;
    px    = idx[0] ? (PW'(job_cx) - PW'(a)) : (PW'(job_cx) + PW'(a));
    py    = idx[1] ? (PW'(job_cy) - PW'(b)) : (PW'(job_cy) + PW'(b));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_free) begin
        out_valid <= move;
      end
      if (load) begin
        busy <= 1'b1;
        idx  <= '0;
      end else if (move) begin
        idx <= idx + pt_idx_t'(1);
        if (idx == LAST_POINT) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      job_cx   <= cx;
      job_cy   <= cy;
      job_x0   <= x0;
      job_y0   <= y0;
      job_x1   <= x1;
      job_y1   <= y1;
      job_done <= done;
    end
    if (move) begin
      point_x  <= px[COORD_BITS:0];
      point_y  <= py[COORD_BITS:0];
      last     <= (idx == LAST_POINT);
      finished <= job_done;
    end
  end

endmodule

@@ tb/circle_checker.sv @@
`timescale 1ns / 1ps
module circle_checker import cpg_pkg::*; #(
  parameter int COORD_BITS = 10
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic                         kind,
  input  logic signed [COORD_BITS-1:0] center_x,
  input  logic signed [COORD_BITS-1:0] center_y,
  input  logic [COORD_BITS-2:0]        radius,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic signed [COORD_BITS:0]   point_x,
  input  logic signed [COORD_BITS:0]   point_y,
  input  logic                         last,
  input  logic                         finished,
  output int                           errors,
  output int                           pending
);

  typedef struct packed {
    logic signed [COORD_BITS:0] px;
    logic signed [COORD_BITS:0] py;
    logic                       last;
    logic                       fin;
  } point_t;

  point_t expected_points[$];
  point_t step_pts[$];
  point_t head;

  int  cur_x;
  int  cur_y;
  int  dvar;
  int  hold_cx;
  int  hold_cy;
  bit  drawing;
  int  err_count = 0;

  task add_octants(input int a, input int b);
    int     i;
    int     sx;
    int     sy;
    int     u;
    int     v;
    point_t p;
    for (i = 0; i < 8; i++) begin
      sx = (i % 2 == 1) ? -1 : 1;
      sy = ((i % 4) >= 2) ? -1 : 1;
      u = (i < 4) ? a : b;
      v = (i < 4) ? b : a;
      p.px = (COORD_BITS+1)'(hold_cx + sx * u);
      p.py = (COORD_BITS+1)'(hold_cy + sy * v);
      p.last = 1'b0;
      p.fin = 1'b0;
      step_pts.push_back(p);
    end
  endtask

  task rasterize_step;
    bit     done;
    int     i;
    point_t p;
    step_pts.delete();
    add_octants(cur_x, cur_y);
    cur_x = cur_x + 1;
    if (dvar < 0) begin
      dvar = dvar + 4 * cur_x + D_STEP_X;
    end else begin
      cur_y = cur_y - 1;
      dvar = dvar + 4 * (cur_x - cur_y) + D_STEP_XY;
    end
    add_octants(cur_x, cur_y);
    done = cur_x > cur_y;
    if (done) drawing = 1'b0;
    for (i = 0; i < step_pts.size(); i++) begin
      p = step_pts[i];
      p.fin = done;
      p.last = (i == step_pts.size() - 1);
      expected_points.push_back(p);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      cur_x = 0;
      cur_y = 0;
      dvar = 0;
      hold_cx = 0;
      hold_cy = 0;
      drawing = 1'b0;
      expected_points.delete();
    end else begin
      if (in_valid && in_ready) begin
        if (kind == KIND_START) begin
          hold_cx = int'(center_x);
          hold_cy = int'(center_y);
          cur_x = 0;
          cur_y = int'(radius);
          dvar = D_INIT - 2 * cur_y;
          drawing = 1'b1;
        end else if (!drawing || cur_x > cur_y) begin
          drawing = 1'b0;
        end else begin
          rasterize_step();
        end
      end
      if (out_valid && out_ready) begin
        if (expected_points.size() == 0) begin
          $display("%0t: unexpected word: expected none, got x=%0d y=%0d last=%0b fin=%0b",
                   $time, point_x, point_y, last, finished);
          err_count++;
        end else begin
          head = expected_points.pop_front();
          if (point_x !== head.px) begin
            $display("%0t: point_x mismatch: expected %0d, got %0d",
                     $time, $signed(head.px), point_x);
            err_count++;
          end
          if (point_y !== head.py) begin
            $display("%0t: point_y mismatch: expected %0d, got %0d",
                     $time, $signed(head.py), point_y);
            err_count++;
          end
          if (last !== head.last) begin
            $display("%0t: last mismatch: expected %0b, got %0b", $time, head.last, last);
            err_count++;
          end
          if (finished !== head.fin) begin
            $display("%0t: finished mismatch: expected %0b, got %0b",
                     $time, head.fin, finished);
            err_count++;
          end
        end
      end
    end
    errors <= err_count;
    pending <= expected_points.size();
  end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
  import cpg_pkg::*;

  localparam int COORD_BITS  = 10;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN       = 40;
  localparam int ITEM_TARGET = 180;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic                         kind = KIND_START;
  logic signed [COORD_BITS-1:0] center_x = '0;
  logic signed [COORD_BITS-1:0] center_y = '0;
  logic [COORD_BITS-2:0]        radius = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic signed [COORD_BITS:0]   point_x;
  logic signed [COORD_BITS:0]   point_y;
  logic                         last;
  logic                         finished;

  int errors;
  int pending;
  int cycle_count = 0;
  int stall_left = 0;
  int calm_left = 0;
  bit draining = 1'b0;
  bit quiet_in = 1'b0;

  circle_point_generator #(.COORD_BITS(COORD_BITS)) u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .kind(kind), .center_x(center_x), .center_y(center_y), .radius(radius),
    .out_valid(out_valid), .out_ready(out_ready),
    .point_x(point_x), .point_y(point_y), .last(last), .finished(finished)
  );

  circle_checker #(.COORD_BITS(COORD_BITS)) u_chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .kind(kind), .center_x(center_x), .center_y(center_y), .radius(radius),
    .out_valid(out_valid), .out_ready(out_ready),
    .point_x(point_x), .point_y(point_y), .last(last), .finished(finished),
    .errors(errors), .pending(pending)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function int pick_gap();
    if ($urandom_range(0, 99) < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // receiver back-pressure with calm stretches
  always @(posedge clk) begin
    if (rst || draining) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      if (calm_left > 0) calm_left = calm_left - 1;
      else if ($urandom_range(0, 99) < 3) calm_left = $urandom_range(50, 200);
      else if ($urandom_range(0, 99) < 30) stall_left = pick_gap();
    end
  end

  task send_word(input kind_t k, input logic signed [COORD_BITS-1:0] cx,
                 input logic signed [COORD_BITS-1:0] cy, input logic [COORD_BITS-2:0] r);
    int gap;
    gap = (quiet_in || $urandom_range(0, 99) < 60) ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    center_x <= cx;
    center_y <= cy;
    radius <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task send_start(input logic signed [COORD_BITS-1:0] cx,
                  input logic signed [COORD_BITS-1:0] cy, input logic [COORD_BITS-2:0] r);
    send_word(KIND_START, cx, cy, r);
  endtask

  // center and radius are don't-care on an advance word
  task send_advance;
    send_word(KIND_ADVANCE, COORD_BITS'($urandom), COORD_BITS'($urandom),
              (COORD_BITS-1)'($urandom));
  endtask

  initial begin
    int counted;
    int sel;
    int r;
    int k;
    int full_steps;
    int j;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed words
    send_advance();
    send_start(10'sd0, 10'sd0, 9'd0);
    send_advance();
    send_advance();
    send_start(10'sd511, 10'sh200, 9'd511);
    repeat (3) send_advance();
    send_start(10'sh200, 10'sd511, 9'd1);
    repeat (3) send_advance();
    send_start(10'sh155, 10'sh2aa, 9'h0aa);
    repeat (2) send_advance();
    send_start(10'sd0, 10'sd0, 9'd2);
    repeat (3) send_advance();

    // random circles, mostly small, some run past completion
    counted = 0;
    while (counted < ITEM_TARGET) begin
      if ($urandom_range(0, 9) == 0) quiet_in = ~quiet_in;
      sel = $urandom_range(0, 99);
      if (sel < 70) r = $urandom_range(0, 15);
      else if (sel < 90) r = $urandom_range(16, 100);
      else r = $urandom_range(0, 511);
      full_steps = (r * 7) / 10 + 1;
      if (sel < 70 && $urandom_range(0, 1) == 1) k = r + 2;
      else if (sel < 70) k = $urandom_range(1, full_steps);
      else if (sel < 90) k = $urandom_range(1, (full_steps < 12) ? full_steps : 12);
      else k = $urandom_range(1, (full_steps < 3) ? full_steps : 3);
      send_start(COORD_BITS'($urandom), COORD_BITS'($urandom), (COORD_BITS-1)'(r));
      counted++;
      for (j = 0; j < k; j++) begin
        send_advance();
        counted++;
      end
      if ($urandom_range(0, 99) < 5) begin
        send_advance();
        counted++;
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    draining = 1'b1;
    repeat (DRAIN) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
